FILE: rtl/assert_macros.svh
// Assertion macros for the port checks of the sphere warp block.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked check, masked while reset is asserted.
`define SWA_ASSERT(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("sphere warp check failed");

// Clocked check that also runs during reset.
`define SWA_ASSERT_RST(lbl, clk, prop) \
  lbl: assert property (@(posedge clk) prop) \
    else $error("sphere warp reset check failed");

`endif

FILE: rtl/swa_pkg.sv
// Shared constants, types and the square-root step of the sphere warp block.
// No dependencies.
package swa_pkg;

  localparam int LINE_STRIDE = 320;
  localparam int MAX_DIM     = 1024;

  localparam int DIM_W      = 11;
  localparam int CRD_W      = 10;
  localparam int DX_W       = 12;
  localparam int R_W        = 17;
  localparam int A_W        = 17;
  localparam int F_W        = 18;
  localparam int GAIN_W     = 16;
  localparam int SCROLL_W   = 10;
  localparam int ADDR_W     = 20;
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int SQ_W       = 40;
  localparam int ROOT_W     = 20;

  localparam logic [R_W-1:0] RADIUS_ONE = 17'd65536;
  localparam logic [16:0]    SCALE_101  = 17'd66191;
  localparam logic [F_W-1:0] FACTOR_MAX = 18'd262143;

  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_WIDTH  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IMAGE_HEIGHT = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_SCROLL       = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SPREAD_GAIN  = 4'd3;

  localparam logic [DIM_W-1:0]    RST_WIDTH  = 11'd320;
  localparam logic [DIM_W-1:0]    RST_HEIGHT = 11'd200;
  localparam logic [SCROLL_W-1:0] RST_SCROLL = 10'd0;
  localparam logic [GAIN_W-1:0]   RST_GAIN   = 16'd25723;

  localparam int CORDIC_N = 16;
  localparam logic [16:0] ATAN_Q16 [CORDIC_N] = '{
    17'd51472, 17'd30386, 17'd16055, 17'd8150, 17'd4091, 17'd2047, 17'd1024, 17'd512,
    17'd256, 17'd128, 17'd64, 17'd32, 17'd16, 17'd8, 17'd4, 17'd2
  };

  typedef struct packed {
    logic [DIM_W-1:0]    w;
    logic [DIM_W-1:0]    h;
    logic [DIM_W-1:0]    m;
    logic [SCROLL_W-1:0] scroll;
    logic [GAIN_W-1:0]   gain;
  } cfg_t;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic                   outside;
    logic [R_W-1:0]         r;
  } rad_t;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic                   outside;
    logic [R_W-1:0]         r;
    logic [A_W-1:0]         a;
  } ang_t;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic                   outside;
    logic [F_W-1:0]         f;
  } fac_t;

  typedef struct packed {
    logic              outside;
    logic [CRD_W-1:0]  src_x;
    logic [CRD_W-1:0]  src_y;
    logic [ADDR_W-1:0] src_address;
  } res_t;

  typedef struct packed {
    logic [SQ_W-1:0]   rem;
    logic [ROOT_W-1:0] root;
  } sq_t;

  // One restoring square-root digit: try root bit k.
  function automatic sq_t sqrt_step(sq_t cur, int unsigned k);
    logic [SQ_W-1:0] t;
    sq_t nxt;
    t = ({{(SQ_W-ROOT_W){1'b0}}, cur.root} << (k + 1)) | ({{(SQ_W-1){1'b0}}, 1'b1} << (2 * k));
    nxt = cur;
    if (cur.rem >= t) begin
      nxt.rem  = cur.rem - t;
      nxt.root = cur.root | ({{(ROOT_W-1){1'b0}}, 1'b1} << k);
    end
    return nxt;
  endfunction

endpackage

FILE: rtl/swa_radius.sv
// Offset, distance square root and normalized radius divide.
// Depends on swa_pkg.
module swa_radius (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      en,
  input  logic                      in_valid,
  input  logic [swa_pkg::CRD_W-1:0] in_x,
  input  logic [swa_pkg::CRD_W-1:0] in_y,
  input  swa_pkg::cfg_t             cfg,
  output logic                      out_valid,
  output swa_pkg::rad_t             out_rad
);
  import swa_pkg::*;

  localparam int SQ_N = 20;
  localparam int DV_N = 17;
  localparam int LAT  = 3 + SQ_N + 1 + 1 + DV_N + 1;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
  } dxy_t;

  typedef struct packed {
    logic [28:0]    rem;
    logic [R_W-1:0] q;
    logic           ovf;
    dxy_t           d;
  } dv_t;

  logic [LAT-1:0]  v_r;
  dxy_t            a_r;
  logic [23:0]     sqx_r, sqy_r;
  dxy_t            b_r;
  sq_t             sq_r  [SQ_N+1];
  dxy_t            sqd_r [SQ_N+1];
  logic [28:0]     p_r;
  dxy_t            pd_r;
  dv_t             dv_r  [DV_N+1];
  rad_t            out_r;

  logic signed [12:0] dx_full, dy_full;
  logic [36:0]        prod;
  logic [28:0]        m_top;

  assign dx_full = $signed({2'b00, in_x, 1'b0}) - $signed({2'b00, cfg.w}) + 13'sd1;
  assign dy_full = $signed({2'b00, in_y, 1'b0}) - $signed({2'b00, cfg.h}) + 13'sd1;
  assign prod    = sq_r[SQ_N].root * SCALE_101;
  assign m_top   = {1'b0, cfg.m, 17'd0};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      a_r.dx <= dx_full[DX_W-1:0];
      a_r.dy <= dy_full[DX_W-1:0];
      sqx_r  <= 24'(a_r.dx * a_r.dx);
      sqy_r  <= 24'(a_r.dy * a_r.dy);
      b_r    <= a_r;
      sq_r[0].rem  <= {sqx_r + sqy_r, 16'd0};
      sq_r[0].root <= '0;
      sqd_r[0]     <= b_r;
      for (int j = 0; j < SQ_N; j++) begin
        sq_r[j+1]  <= sqrt_step(sq_r[j], SQ_N - 1 - j);
        sqd_r[j+1] <= sqd_r[j];
      end
      p_r  <= prod[36:8];
      pd_r <= sqd_r[SQ_N];
      dv_r[0].rem <= p_r;
      dv_r[0].q   <= '0;
      dv_r[0].ovf <= (p_r >= m_top);
      dv_r[0].d   <= pd_r;
      for (int j = 0; j < DV_N; j++) begin
        dv_r[j+1].ovf <= dv_r[j].ovf;
        dv_r[j+1].d   <= dv_r[j].d;
        if (dv_r[j].rem >= (29'(cfg.m) << (DV_N - 1 - j))) begin
          dv_r[j+1].rem <= dv_r[j].rem - (29'(cfg.m) << (DV_N - 1 - j));
          dv_r[j+1].q   <= dv_r[j].q | (17'd1 << (DV_N - 1 - j));
        end else begin
          dv_r[j+1].rem <= dv_r[j].rem;
          dv_r[j+1].q   <= dv_r[j].q;
        end
      end
      out_r.dx      <= dv_r[DV_N].d.dx;
      out_r.dy      <= dv_r[DV_N].d.dy;
      out_r.r       <= dv_r[DV_N].q;
      out_r.outside <= dv_r[DV_N].ovf | (dv_r[DV_N].q > RADIUS_ONE);
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_rad   = out_r;

endmodule

FILE: rtl/swa_asin.sv
// Cosine square root and vectoring CORDIC giving asin of the radius.
// Depends on swa_pkg.
module swa_asin (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  swa_pkg::rad_t in_rad,
  output logic          out_valid,
  output swa_pkg::ang_t out_ang
);
  import swa_pkg::*;

  localparam int SQ_N = 17;
  localparam int LAT  = 1 + 1 + SQ_N + 1 + CORDIC_N + 1;

  typedef struct packed {
    logic signed [19:0] x;
    logic signed [19:0] y;
    logic signed [17:0] z;
  } cr_t;

  function automatic cr_t cordic_step(cr_t c, int unsigned i);
    cr_t n;
    logic signed [19:0] xs, ys;
    logic signed [17:0] ang;
    xs  = $signed(c.x) >>> i;
    ys  = $signed(c.y) >>> i;
    ang = $signed({1'b0, ATAN_Q16[i]});
    if (!c.y[19]) begin
      n.x = c.x + ys;
      n.y = c.y - xs;
      n.z = c.z + ang;
    end else begin
      n.x = c.x - ys;
      n.y = c.y + xs;
      n.z = c.z - ang;
    end
    return n;
  endfunction

  logic [LAT-1:0] v_r;
  logic [33:0]    rr_r;
  rad_t           rr_d_r;
  sq_t            sq_r   [SQ_N+1];
  rad_t           sqd_r  [SQ_N+1];
  cr_t            cr_r   [CORDIC_N+1];
  rad_t           crd_r  [CORDIC_N+1];
  ang_t           out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rr_r   <= in_rad.r * in_rad.r;
      rr_d_r <= in_rad;
      // 1 - r^2 in Q32; wraps for outside pixels, which are dropped later
      sq_r[0].rem  <= {6'd0, 34'h1_0000_0000 - rr_r};
      sq_r[0].root <= '0;
      sqd_r[0]     <= rr_d_r;
      for (int j = 0; j < SQ_N; j++) begin
        sq_r[j+1]  <= sqrt_step(sq_r[j], SQ_N - 1 - j);
        sqd_r[j+1] <= sqd_r[j];
      end
      cr_r[0].x <= $signed({3'b000, sq_r[SQ_N].root[16:0]});
      cr_r[0].y <= $signed({3'b000, sqd_r[SQ_N].r});
      cr_r[0].z <= '0;
      crd_r[0]  <= sqd_r[SQ_N];
      for (int j = 0; j < CORDIC_N; j++) begin
        cr_r[j+1]  <= cordic_step(cr_r[j], j);
        crd_r[j+1] <= crd_r[j];
      end
      out_r.dx      <= crd_r[CORDIC_N].dx;
      out_r.dy      <= crd_r[CORDIC_N].dy;
      out_r.outside <= crd_r[CORDIC_N].outside;
      out_r.r       <= crd_r[CORDIC_N].r;
      out_r.a       <= cr_r[CORDIC_N].z[17] ? '0 : cr_r[CORDIC_N].z[16:0];
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_ang   = out_r;

endmodule

FILE: rtl/swa_factor.sv
// Scale factor asin(r)/(r*gain), or 1/gain at r = 0, by a pipelined restoring divide, saturated.
// Depends on swa_pkg.
module swa_factor (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  swa_pkg::ang_t in_ang,
  input  swa_pkg::cfg_t cfg,
  output logic          out_valid,
  output swa_pkg::fac_t out_fac
);
  import swa_pkg::*;

  localparam int DV_N = F_W;
  localparam int LAT  = 1 + 1 + DV_N + 1;

  typedef struct packed {
    logic signed [DX_W-1:0] dx;
    logic signed [DX_W-1:0] dy;
    logic                   outside;
  } side_t;

  typedef struct packed {
    logic [51:0]    rem;
    logic [32:0]    d;
    logic [F_W-1:0] q;
    logic           sat;
    side_t          s;
  } dv_t;

  logic [LAT-1:0] v_r;
  logic [32:0]    d_r;
  logic [46:0]    n_r;
  side_t          s_r;
  dv_t            dv_r [DV_N+1];
  fac_t           out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      if (in_ang.r == '0) begin
        d_r <= 33'(cfg.gain);
        n_r <= 47'd1 << 30;
      end else begin
        d_r <= in_ang.r * cfg.gain;
        n_r <= {in_ang.a, 30'd0};
      end
      s_r.dx      <= in_ang.dx;
      s_r.dy      <= in_ang.dy;
      s_r.outside <= in_ang.outside;
      dv_r[0].rem <= 52'(n_r);
      dv_r[0].d   <= d_r;
      dv_r[0].q   <= '0;
      dv_r[0].sat <= (52'(n_r) >= (52'(d_r) << DV_N));
      dv_r[0].s   <= s_r;
      for (int j = 0; j < DV_N; j++) begin
        dv_r[j+1].d   <= dv_r[j].d;
        dv_r[j+1].sat <= dv_r[j].sat;
        dv_r[j+1].s   <= dv_r[j].s;
        if (dv_r[j].rem >= (52'(dv_r[j].d) << (DV_N - 1 - j))) begin
          dv_r[j+1].rem <= dv_r[j].rem - (52'(dv_r[j].d) << (DV_N - 1 - j));
          dv_r[j+1].q   <= dv_r[j].q | (18'd1 << (DV_N - 1 - j));
        end else begin
          dv_r[j+1].rem <= dv_r[j].rem;
          dv_r[j+1].q   <= dv_r[j].q;
        end
      end
      out_r.dx      <= dv_r[DV_N].s.dx;
      out_r.dy      <= dv_r[DV_N].s.dy;
      out_r.outside <= dv_r[DV_N].s.outside;
      out_r.f       <= dv_r[DV_N].sat ? FACTOR_MAX : dv_r[DV_N].q;
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_fac   = out_r;

endmodule

FILE: rtl/swa_map.sv
// Source coordinate mapping, modulo-width wrap and linear address.
// Depends on swa_pkg.
module swa_map (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          en,
  input  logic          in_valid,
  input  swa_pkg::fac_t in_fac,
  input  swa_pkg::cfg_t cfg,
  output logic          out_valid,
  output swa_pkg::res_t out_res
);
  import swa_pkg::*;

  localparam int MD_N = 13;
  localparam int LAT  = 1 + 1 + MD_N + 1;

  typedef struct packed {
    logic [MD_N-1:0]  rem;
    logic [CRD_W-1:0] sy;
    logic             outside;
  } md_t;

  logic [LAT-1:0]     v_r;
  logic signed [30:0] px_r, py_r;
  logic               po_r;
  md_t                md_r [MD_N+1];
  res_t               out_r;

  logic [DIM_W-1:0]   wm1, hm1;
  logic signed [31:0] sxs, sys;
  logic [MD_N-1:0]    sx13, sy13;
  logic [10:0]        sx_fin;
  logic [21:0]        addr_full;

  assign wm1  = cfg.w - 11'd1;
  assign hm1  = cfg.h - 11'd1;
  assign sxs  = 32'(px_r) + $signed({5'd0, wm1, 16'd0}) + $signed({5'd0, cfg.scroll, 17'd0});
  assign sys  = 32'(py_r) + $signed({5'd0, hm1, 16'd0});
  assign sx13 = sxs[31] ? '0 : sxs[29:17];
  assign sy13 = sys[31] ? '0 : sys[29:17];

  assign sx_fin    = md_r[MD_N].rem[10:0];
  assign addr_full = 22'(md_r[MD_N].sy) * 22'(LINE_STRIDE) + 22'(sx_fin);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[LAT-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      px_r <= in_fac.dx * $signed({1'b0, in_fac.f});
      py_r <= in_fac.dy * $signed({1'b0, in_fac.f});
      po_r <= in_fac.outside;
      md_r[0].rem     <= sx13;
      md_r[0].sy      <= (|sy13[12:10]) ? 10'd1023 : sy13[9:0];
      md_r[0].outside <= po_r;
      for (int j = 0; j < MD_N; j++) begin
        md_r[j+1].sy      <= md_r[j].sy;
        md_r[j+1].outside <= md_r[j].outside;
        if (24'(md_r[j].rem) >= (24'(cfg.w) << (MD_N - 1 - j))) begin
          md_r[j+1].rem <= 13'(24'(md_r[j].rem) - (24'(cfg.w) << (MD_N - 1 - j)));
        end else begin
          md_r[j+1].rem <= md_r[j].rem;
        end
      end
      if (md_r[MD_N].outside) begin
        out_r <= '{outside: 1'b1, src_x: '0, src_y: '0, src_address: '0};
      end else begin
        out_r.outside     <= 1'b0;
        out_r.src_x       <= sx_fin[CRD_W-1:0];
        out_r.src_y       <= md_r[MD_N].sy;
        out_r.src_address <= addr_full[ADDR_W-1:0];
      end
    end
  end

  assign out_valid = v_r[LAT-1];
  assign out_res   = out_r;

endmodule

FILE: rtl/sphere_warp_address.sv
// Sphere warp address generator: one output pixel in, one source address out.
// Register stages: radius 43, asin 37, factor 21 and mapping 16;
// throughput one transaction per cycle unless a result is held at the output.
// A stalled result freezes every stage; nothing is lost or repeated.
// Synchronous active-low reset clears all valid bits and loads register defaults.
// Depends on swa_pkg and the swa_radius, swa_asin, swa_factor, swa_map stages.
module sphere_warp_address (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [swa_pkg::CRD_W-1:0]      in_out_x,
  input  logic [swa_pkg::CRD_W-1:0]      in_out_y,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           out_outside,
  output logic [swa_pkg::CRD_W-1:0]      out_src_x,
  output logic [swa_pkg::CRD_W-1:0]      out_src_y,
  output logic [swa_pkg::ADDR_W-1:0]     out_src_address,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [swa_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [swa_pkg::CFG_DATA_W-1:0] cfg_data
);
  import swa_pkg::*;

  // Configuration registers
  logic [DIM_W-1:0]    image_width_r;
  logic [DIM_W-1:0]    image_height_r;
  logic [SCROLL_W-1:0] scroll_offset_r;
  logic [GAIN_W-1:0]   spread_gain_r;

  cfg_t cfg;
  logic en;

  logic rad_v, ang_v, fac_v, res_v;
  rad_t rad;
  ang_t ang;
  fac_t fac;
  res_t res;

  // Writes are always taken; unknown indexes are dropped.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      image_width_r   <= RST_WIDTH;
      image_height_r  <= RST_HEIGHT;
      scroll_offset_r <= RST_SCROLL;
      spread_gain_r   <= RST_GAIN;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_IMAGE_WIDTH:  image_width_r   <= cfg_data[DIM_W-1:0];
        REG_IMAGE_HEIGHT: image_height_r  <= cfg_data[DIM_W-1:0];
        REG_SCROLL:       scroll_offset_r <= cfg_data[SCROLL_W-1:0];
        REG_SPREAD_GAIN:  spread_gain_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  // Effective settings: dimensions clamped to 2..MAX_DIM, zero gain read as 1.
  // Change registers only with an empty pipe (not enforced); stages read them live.
  always_comb begin
    if (image_width_r < 11'd2)             cfg.w = 11'd2;
    else if (int'(image_width_r) > MAX_DIM) cfg.w = DIM_W'(MAX_DIM);
    else                                   cfg.w = image_width_r;
    if (image_height_r < 11'd2)             cfg.h = 11'd2;
    else if (int'(image_height_r) > MAX_DIM) cfg.h = DIM_W'(MAX_DIM);
    else                                    cfg.h = image_height_r;
    cfg.m      = ((cfg.w < cfg.h) ? cfg.w : cfg.h) - 11'd1;
    cfg.scroll = scroll_offset_r;
    cfg.gain   = (spread_gain_r == '0) ? 16'd1 : spread_gain_r;
  end

  // Global advance: the whole pipe moves unless a finished result is held.
  // The last stage register doubles as the output register.
  assign en       = out_ready | ~res_v;
  assign in_ready = en;

  // Offset, distance sqrt and radius divide; flags r > 1 as outside.
  swa_radius u_radius (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_valid),
    .in_x      (in_out_x),
    .in_y      (in_out_y),
    .cfg       (cfg),
    .out_valid (rad_v),
    .out_rad   (rad)
  );

  // sqrt(1 - r^2) then 16 CORDIC vectoring iterations for asin(r).
  swa_asin u_asin (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (rad_v),
    .in_rad    (rad),
    .out_valid (ang_v),
    .out_ang   (ang)
  );

  // asin(r)/(r*gain), or 1/gain at the exact center, Q2.16 saturated.
  swa_factor u_factor (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (ang_v),
    .in_ang    (ang),
    .cfg       (cfg),
    .out_valid (fac_v),
    .out_fac   (fac)
  );

  // Scale back, add scroll, wrap x modulo width, clamp y, form the address.
  swa_map u_map (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fac_v),
    .in_fac    (fac),
    .cfg       (cfg),
    .out_valid (res_v),
    .out_res   (res)
  );

  assign out_valid       = res_v;
  assign out_outside     = res.outside;
  assign out_src_x       = res.src_x;
  assign out_src_y       = res.src_y;
  assign out_src_address = res.src_address;

endmodule

FILE: rtl/swa_checker.sv
// Port-level checks for sphere_warp_address and the bind that attaches them.
// Depends on assert_macros.svh.
`include "assert_macros.svh"

module swa_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        in_ready,
  input logic        out_valid,
  input logic        out_ready,
  input logic        out_outside,
  input logic [9:0]  out_src_x,
  input logic [9:0]  out_src_y,
  input logic [19:0] out_src_address
);

  // Reset empties the pipe.
  `SWA_ASSERT_RST(a_reset_empties, clk, !rst_n |=> !out_valid)

  // Input side stalls exactly when a result is held.
  `SWA_ASSERT(a_ready_follows_out, clk, rst_n, in_ready == (out_ready || !out_valid))

  // A held result does not change.
  `SWA_ASSERT(a_out_hold, clk, rst_n, out_valid && !out_ready |=> out_valid && $stable(out_src_address) && $stable(out_outside))

  // Outside pixels carry a zero coordinate and address.
  `SWA_ASSERT(a_outside_zero, clk, rst_n, out_valid && out_outside |-> out_src_x == 10'd0 && out_src_y == 10'd0 && out_src_address == 20'd0)

endmodule

bind sphere_warp_address swa_checker u_swa_checker (.*);

FILE: dv/sphere_warp_address_tb.sv
// Self-checking testbench for sphere_warp_address: drives pixel coordinates and
// register writes, and checks each source address against a built-in predictor.
// Depends on swa_pkg and the sphere_warp_address RTL.
module sphere_warp_address_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import swa_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int DRAIN_CYCLES = 150;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  logic [CRD_W-1:0]      in_out_x;
  logic [CRD_W-1:0]      in_out_y;
  logic                  out_valid;
  logic                  out_ready;
  logic                  out_outside;
  logic [CRD_W-1:0]      out_src_x;
  logic [CRD_W-1:0]      out_src_y;
  logic [ADDR_W-1:0]     out_src_address;
  logic                  cfg_valid;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  sphere_warp_address dut (.*);

  // Warp predictor plus the queue of source addresses still owed by the block.
  class warp_scoreboard;
    longint unsigned width, height, scroll, gain;
    res_t            pending[$];
    int              mismatches;

    function new();
      width  = RST_WIDTH;
      height = RST_HEIGHT;
      scroll = RST_SCROLL;
      gain   = RST_GAIN;
      mismatches = 0;
    endfunction

    task report(string what);
      mismatches++;
      $display("[%0t] mismatch: %s", $realtime, what);
    endtask

    function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
      case (idx)
        REG_IMAGE_WIDTH:  width  = val & 16'h07FF;
        REG_IMAGE_HEIGHT: height = val & 16'h07FF;
        REG_SCROLL:       scroll = val & 16'h03FF;
        REG_SPREAD_GAIN:  gain   = val;
        default: ;
      endcase
    endfunction

    static function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned root, bit_w;
      root  = 0;
      bit_w = 64'd1 << 62;
      while (bit_w > v) bit_w >>= 2;
      while (bit_w != 0) begin
        if (v >= root + bit_w) begin
          v    -= root + bit_w;
          root  = (root >> 1) + bit_w;
        end else begin
          root >>= 1;
        end
        bit_w >>= 2;
      end
      return root;
    endfunction

    // asin of a Q1.16 radius by vectoring CORDIC, Q16 angle
    static function longint arcsine(longint r);
      longint cx, cy, ang, xs, ys;
      cx  = longint'(int_sqrt((64'd1 << 32) - longint'(r * r)));
      cy  = r;
      ang = 0;
      for (int i = 0; i < CORDIC_N; i++) begin
        xs = cx >>> i;
        ys = cy >>> i;
        if (cy >= 0) begin
          cx += ys; cy -= xs; ang += longint'(ATAN_Q16[i]);
        end else begin
          cx -= ys; cy += xs; ang -= longint'(ATAN_Q16[i]);
        end
      end
      return (ang < 0) ? 0 : ang;
    endfunction

    static function longint clamp_dim(longint d);
      if (d < 2) return 2;
      if (d > MAX_DIM) return MAX_DIM;
      return d;
    endfunction

    function void note_pixel(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
      longint w, h, g, dx, dy, m, s, r, f, sx, sy;
      res_t   e;
      w  = clamp_dim(width);
      h  = clamp_dim(height);
      g  = (gain == 0) ? 1 : longint'(gain);
      dx = 2 * longint'(px) - (w - 1);
      dy = 2 * longint'(py) - (h - 1);
      m  = ((w < h) ? w : h) - 1;
      s  = longint'(int_sqrt(longint'(dx * dx + dy * dy) << 16));
      r  = (s * longint'(SCALE_101)) / (m * 256);
      e  = '0;
      if (r > longint'(RADIUS_ONE)) begin
        e.outside = 1'b1;
      end else begin
        if (r == 0) f = (longint'(1) << 30) / g;
        else        f = (arcsine(r) << 30) / (r * g);
        if (f > longint'(FACTOR_MAX)) f = longint'(FACTOR_MAX);
        sx = dx * f + (w - 1) * 65536 + longint'(scroll) * 131072;
        sy = dy * f + (h - 1) * 65536;
        sx = (sx < 0) ? 0 : (sx >>> 17);
        sy = (sy < 0) ? 0 : (sy >>> 17);
        sx = sx % w;
        if (sy > 1023) sy = 1023;
        e.src_x       = sx[CRD_W-1:0];
        e.src_y       = sy[CRD_W-1:0];
        e.src_address = 20'(sy * LINE_STRIDE + sx);
      end
      pending.push_back(e);
    endfunction

    task check_result(res_t got);
      res_t e;
      if (pending.size() == 0) begin
        report("result with nothing outstanding");
        return;
      end
      e = pending.pop_front();
      if (got.outside !== e.outside)
        report($sformatf("outside got %0b exp %0b", got.outside, e.outside));
      if (got.src_x !== e.src_x)
        report($sformatf("src_x got %0d exp %0d", got.src_x, e.src_x));
      if (got.src_y !== e.src_y)
        report($sformatf("src_y got %0d exp %0d", got.src_y, e.src_y));
      if (got.src_address !== e.src_address)
        report($sformatf("src_address got %0d exp %0d", got.src_address, e.src_address));
    endtask
  endclass

  warp_scoreboard sb;

  // Idle rates in percent, changed per phase by the main sequence.
  int send_idle_pct;
  int recv_idle_pct;
  bit stall_request;   // ask the receiver for one long hold-off
  int stall_left;
  longint cycle_count;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Receiver: random back-pressure, plus a long hold-off on request so the
  // pipeline fills and in_ready drops while the sender keeps offering.
  always @(negedge clk) begin
    if (stall_request) begin
      stall_request = 1'b0;
      stall_left    = 400;
    end
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Result monitor: sampled at the rising edge, before the block updates.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready)
      sb.check_result('{out_outside, out_src_x, out_src_y, out_src_address});
  end

  // Watchdog on total run length.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > LIMIT_CYCLES) begin
      $display("timeout after %0d cycles", cycle_count);
      $display("FAIL sphere_warp_address");
      $finish;
    end
  end

  // One input transaction; valid holds until the block accepts it.
  task automatic send_pixel(logic [CRD_W-1:0] px, logic [CRD_W-1:0] py);
    @(negedge clk);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid <= 1'b1;
    in_out_x <= px;
    in_out_y <= py;
    do @(posedge clk); while (!in_ready);
    sb.note_pixel(px, py);
  endtask

  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk);
  endtask

  // Register write; only issued with nothing in flight.
  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    sb.write_reg(idx, val);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // Mostly pixels inside the configured image, the rest anywhere.
  task automatic send_random(int count);
    longint w, h;
    w = warp_scoreboard::clamp_dim(sb.width);
    h = warp_scoreboard::clamp_dim(sb.height);
    repeat (count) begin
      if ($urandom_range(99) < 75)
        send_pixel(CRD_W'($urandom_range(w - 1)), CRD_W'($urandom_range(h - 1)));
      else
        send_pixel(CRD_W'($urandom_range(1023)), CRD_W'($urandom_range(1023)));
    end
  endtask

  // Corners of the field range plus the image centre.
  task automatic send_corners();
    longint w, h;
    w = warp_scoreboard::clamp_dim(sb.width);
    h = warp_scoreboard::clamp_dim(sb.height);
    send_pixel(0, 0);
    send_pixel(1023, 1023);
    send_pixel(0, 1023);
    send_pixel(1023, 0);
    send_pixel(CRD_W'((w - 1) / 2), CRD_W'((h - 1) / 2));
  endtask

  task automatic configure(logic [15:0] w, logic [15:0] h, logic [15:0] sc, logic [15:0] g);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    write_reg(REG_SCROLL, sc);
    write_reg(REG_SPREAD_GAIN, g);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 15;
    recv_idle_pct = 79;
    stall_request = 1'b0;
    stall_left    = 0;
    cycle_count   = 0;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_out_x  = '0;
    in_out_y  = '0;
    out_ready = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    repeat (5) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Reset defaults first, then the same values written back explicitly.
    send_corners();
    send_pixel(159, 99);
    send_pixel(160, 100);
    wait_drained();
    configure(16'd320, 16'd200, 16'd0, 16'd25723);
    send_random(300);

    // Smallest image, largest scroll and gain; stray indexes must be ignored.
    wait_drained();
    configure(16'd2, 16'd2, 16'd1023, 16'd65535);
    write_reg(4'd9, 16'hFFFF);
    write_reg(4'd15, 16'h0001);
    send_corners();
    send_pixel(1, 1);
    send_random(300);

    send_idle_pct = 79;
    recv_idle_pct = 15;
    // Largest image, unity gain: factor saturates.
    wait_drained();
    configure(16'd1024, 16'd1024, 16'd512, 16'd1);
    send_corners();
    send_random(300);

    // Out-of-range dimensions clamp, zero gain is treated as one.
    wait_drained();
    configure(16'd0, 16'hFFFF, 16'hFC07, 16'd0);
    send_corners();
    send_random(300);

    send_idle_pct = 0;
    recv_idle_pct = 0;
    // Odd dimensions put a pixel exactly on the centre.
    wait_drained();
    configure(16'd321, 16'd201, 16'd100, 16'd16384);
    send_corners();
    stall_request = 1'b1;
    send_random(350);

    // A few random settings.
    repeat (3) begin
      wait_drained();
      configure(16'($urandom_range(1024, 2)), 16'($urandom_range(1024, 2)),
                16'($urandom_range(1023)), 16'($urandom_range(65535, 1)));
      send_random(110);
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (sb.mismatches == 0 && sb.pending.size() == 0)
      $display("PASS sphere_warp_address");
    else
      $display("FAIL sphere_warp_address");
    $finish;
  end

endmodule
